[sv/nbga_pkg.sv]
// ----------------------------------------------------------------------------
// nbga_pkg
// Shared types and constants of the direct-sum gravity block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nbga_pkg;

   localparam int DATA_W    = 32;
   localparam int IDX_W     = 6;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOFTEN  = 2'd1;

   // clamp of the running sums and of each contribution
   localparam logic [63:0] ACC_LIM = 64'h2000_0000_0000_0000;

   typedef struct packed {
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
      logic [DATA_W-1:0] z;
      logic [DATA_W-1:0] m;
   } particle_type;

   typedef struct packed {
      particle_type pi;
      particle_type pj;
   } pair_req_type;

   typedef struct packed {
      logic [63:0] cx;
      logic [63:0] cy;
      logic [63:0] cz;
   } pair_rsp_type;

endpackage

`default_nettype wire

[sv/nbga_cell.sv]
// ----------------------------------------------------------------------------
// nbga_cell
// One particle slot of the storage ring: loads from the port, shifts from
// its neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nbga_cell (
   input  wire                   clock,
   input  wire                   load_en,
   input  nbga_pkg::particle_type load_data,
   input  wire                   shift_en,
   input  nbga_pkg::particle_type shift_data,
   output nbga_pkg::particle_type q
);
   import nbga_pkg::*;

   particle_type data_ff;

   always_ff @(posedge clock) begin
      if (load_en) begin
         data_ff <= load_data;
      end else if (shift_en) begin
         data_ff <= shift_data;
      end
   end

   assign q = data_ff;

endmodule

`default_nettype wire

[sv/nbga_pair.sv]
// ----------------------------------------------------------------------------
// nbga_pair
// Softened gravity term of one particle pair: squares, bit-serial square
// root, split product, bit-serial divide, split scaling per axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nbga_pair #(
   parameter int FRAC_BITS = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  nbga_pkg::pair_req_type req,
   input  wire [31:0]             gravity_const,
   input  wire [31:0]             softening_length,
   output logic                   done,
   output nbga_pkg::pair_rsp_type rsp
);
   import nbga_pkg::*;

   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_DIFF = 3'd1;
   localparam logic [2:0] P_MUL  = 3'd2;
   localparam logic [2:0] P_SQRT = 3'd3;
   localparam logic [2:0] P_SR   = 3'd4;
   localparam logic [2:0] P_DIV  = 3'd5;
   localparam logic [2:0] P_CON  = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [5:0]    cnt_ff, cnt_in;
   pair_req_type  req_ff, req_in;
   logic [32:0]   ux_ff, uy_ff, uz_ff, ux_in, uy_in, uz_in;
   logic [2:0]    neg_ff, neg_in;
   logic [63:0]   s_ff, s_in;
   logic [63:0]   gm_ff, gm_in;
   logic [65:0]   prod_ff;
   logic [95:0]   x_ff, x_in;
   logic [51:0]   rem_ff, rem_in;
   logic [47:0]   root_ff, root_in;
   logic [127:0]  wacc_ff, wacc_in;
   logic          kzero_ff, kzero_in;
   logic [63:0]   d_ff, d_in;
   logic [63:0]   drem_ff, drem_in;
   logic [63:0]   quo_ff, quo_in;
   logic [97:0]   cacc_ff, cacc_in;
   pair_rsp_type  con_ff, con_in;
   logic          done_ff, done_in;

   logic [32:0]   mul_a, mul_b;
   logic [5:0]    step;
   logic [32:0]   dx, dy, dz;
   logic [63:0]   s_add;
   logic [51:0]   rem_sh, trial;
   logic [127:0]  w_sum, w_sh;
   logic [64:0]   dsh;
   logic [63:0]   kval;
   logic [97:0]   c_sum, c_sh;
   logic [63:0]   c_mag, c_val;

   assign step = cnt_ff - 6'd1;
   assign kval = kzero_ff ? 64'd0 : quo_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         P_MUL: begin
            case (cnt_ff)
               6'd0: begin mul_a = ux_ff; mul_b = ux_ff; end
               6'd1: begin mul_a = uy_ff; mul_b = uy_ff; end
               6'd2: begin mul_a = uz_ff; mul_b = uz_ff; end
               6'd3: begin
                  mul_a = {1'b0, gravity_const};
                  mul_b = {1'b0, req_ff.pj.m};
               end
               default: begin
                  mul_a = {1'b0, softening_length};
                  mul_b = {1'b0, softening_length};
               end
            endcase
         end
         P_SR: begin
            mul_a = cnt_ff[1] ? {1'b0, s_ff[63:32]} : {1'b0, s_ff[31:0]};
            mul_b = cnt_ff[0] ? {17'd0, root_ff[47:32]} : {1'b0, root_ff[31:0]};
         end
         P_CON: begin
            mul_b = cnt_ff[0] ? {1'b0, kval[63:32]} : {1'b0, kval[31:0]};
            case (cnt_ff[2:1])
               2'd0:    mul_a = ux_ff;
               2'd1:    mul_a = uy_ff;
               default: mul_a = uz_ff;
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      dx     = {req_ff.pj.x[31], req_ff.pj.x} - {req_ff.pi.x[31], req_ff.pi.x};
      dy     = {req_ff.pj.y[31], req_ff.pj.y} - {req_ff.pi.y[31], req_ff.pi.y};
      dz     = {req_ff.pj.z[31], req_ff.pj.z} - {req_ff.pi.z[31], req_ff.pi.z};
      s_add  = s_ff + 64'(prod_ff >> FRAC_BITS);
      rem_sh = {rem_ff[49:0], x_ff[95:94]};
      trial  = {2'b00, root_ff, 2'b01};
      w_sum  = wacc_ff + (128'(prod_ff) << ((step == 6'd0) ? 0 :
                                           (step == 6'd3) ? 64 : 32));
      w_sh   = w_sum >> FRAC_BITS;
      dsh    = {drem_ff, quo_ff[63]};
      c_sum  = cacc_ff + (98'(prod_ff) << (step[0] ? 32 : 0));
      c_sh   = c_sum >> FRAC_BITS;
      c_mag  = (c_sh > 98'(ACC_LIM)) ? ACC_LIM : c_sh[63:0];
      c_val  = neg_ff[step[2:1]] ? (64'd0 - c_mag) : c_mag;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + 6'd1;
      req_in   = req_ff;
      ux_in    = ux_ff;
      uy_in    = uy_ff;
      uz_in    = uz_ff;
      neg_in   = neg_ff;
      s_in     = s_ff;
      gm_in    = gm_ff;
      x_in     = x_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      wacc_in  = wacc_ff;
      kzero_in = kzero_ff;
      d_in     = d_ff;
      drem_in  = drem_ff;
      quo_in   = quo_ff;
      cacc_in  = cacc_ff;
      con_in   = con_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         P_IDLE: begin
            cnt_in = '0;
            if (start) begin
               req_in   = req;
               state_in = P_DIFF;
            end
         end
         P_DIFF: begin
            neg_in   = {dz[32], dy[32], dx[32]};
            ux_in    = dx[32] ? 33'd0 - dx : dx;
            uy_in    = dy[32] ? 33'd0 - dy : dy;
            uz_in    = dz[32] ? 33'd0 - dz : dz;
            s_in     = '0;
            cnt_in   = '0;
            state_in = P_MUL;
         end
         P_MUL: begin
            if (cnt_ff != 6'd0) begin
               if (step == 6'd3) begin
                  gm_in = prod_ff[63:0];
               end else begin
                  s_in = s_add;
               end
            end
            if (cnt_ff == 6'd5) begin
               x_in     = 96'(s_add) << FRAC_BITS;
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = P_SQRT;
            end
         end
         P_SQRT: begin
            x_in = x_ff << 2;
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[46:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[46:0], 1'b0};
            end
            if (cnt_ff == 6'd47) begin
               wacc_in  = '0;
               cnt_in   = '0;
               state_in = P_SR;
            end
         end
         P_SR: begin
            if (cnt_ff != 6'd0) begin
               wacc_in = w_sum;
            end
            if (cnt_ff == 6'd4) begin
               kzero_in = |w_sh[127:64];
               d_in     = (w_sh[63:0] == 64'd0) ? 64'd1 : w_sh[63:0];
               drem_in  = '0;
               quo_in   = gm_ff;
               cnt_in   = '0;
               state_in = P_DIV;
            end
         end
         P_DIV: begin
            if (dsh >= {1'b0, d_ff}) begin
               drem_in = 64'(dsh - {1'b0, d_ff});
               quo_in  = {quo_ff[62:0], 1'b1};
            end else begin
               drem_in = dsh[63:0];
               quo_in  = {quo_ff[62:0], 1'b0};
            end
            if (cnt_ff == 6'd63) begin
               cacc_in  = '0;
               cnt_in   = '0;
               state_in = P_CON;
            end
         end
         P_CON: begin
            if (cnt_ff != 6'd0) begin
               if (step[0]) begin
                  cacc_in = '0;
                  case (step[2:1])
                     2'd0:    con_in.cx = c_val;
                     2'd1:    con_in.cy = c_val;
                     default: con_in.cz = c_val;
                  endcase
               end else begin
                  cacc_in = c_sum;
               end
            end
            if (cnt_ff == 6'd6) begin
               done_in  = 1'b1;
               state_in = P_IDLE;
            end
         end
         default: state_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= mul_a * mul_b;
      req_ff   <= req_in;
      ux_ff    <= ux_in;
      uy_ff    <= uy_in;
      uz_ff    <= uz_in;
      neg_ff   <= neg_in;
      s_ff     <= s_in;
      gm_ff    <= gm_in;
      x_ff     <= x_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      wacc_ff  <= wacc_in;
      kzero_ff <= kzero_in;
      d_ff     <= d_in;
      drem_ff  <= drem_in;
      quo_ff   <= quo_in;
      cacc_ff  <= cacc_in;
      con_ff   <= con_in;
   end

   assign done = done_ff;
   assign rsp  = con_ff;

endmodule

`default_nettype wire

[sv/nbody_gravity_acceleration.sv]
// ----------------------------------------------------------------------------
// nbody_gravity_acceleration
// Direct-sum gravity with softening over a ring of particle cells.
// ----------------------------------------------------------------------------
// Loading: one item per cycle while busy is low; a non-final item leaves busy low.
// Compute per particle: one ring turn to seek it, then a scan turn that runs
//   the bit-serial square root and divide for each other particle.
// Results come one per particle, each valid for one cycle, in load order.
// Reset is synchronous; it clears the particle count and the control state.
`timescale 1ns / 1ps
`default_nettype none

module nbody_gravity_acceleration #(
   parameter int MAX_PARTICLES = 64,
   parameter int FRAC_BITS     = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire signed [31:0]                req_pos_x,
   input  wire signed [31:0]                req_pos_y,
   input  wire signed [31:0]                req_pos_z,
   input  wire        [31:0]                req_mass,
   input  wire                              req_last_particle,
   output logic                             rsp_valid,
   output logic signed [31:0]               rsp_acc_x,
   output logic signed [31:0]               rsp_acc_y,
   output logic signed [31:0]               rsp_acc_z,
   output logic [nbga_pkg::IDX_W-1:0]       rsp_particle_index,
   output logic                             rsp_last_result,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [nbga_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [31:0]                       csr_wdata
);
   import nbga_pkg::*;

   localparam int IW    = $clog2(MAX_PARTICLES);
   localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
   localparam logic [IW-1:0]    R_LAST = IW'(MAX_PARTICLES - 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTICLES);

   localparam logic [2:0] T_IDLE = 3'd0;
   localparam logic [2:0] T_SEEK = 3'd1;
   localparam logic [2:0] T_SCAN = 3'd2;
   localparam logic [2:0] T_WAIT = 3'd3;
   localparam logic [2:0] T_EMIT = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IW-1:0]    r_ff, r_in;
   logic [IW-1:0]    i_ff, i_in;
   particle_type     pi_ff, pi_in;
   logic [63:0]      ax_ff, ay_ff, az_ff, ax_in, ay_in, az_in;
   logic [31:0]      grav_ff, soft_ff;
   logic             rv_ff, rv_in, rl_ff, rl_in;
   logic [31:0]      rx_ff, ry_ff, rz_ff, rx_in, ry_in, rz_in;
   logic [IW-1:0]    ri_ff, ri_in;

   particle_type     cell_q [MAX_PARTICLES];
   particle_type     load_data;
   logic             load_en, rot_en, pair_start, pair_done;
   pair_req_type     pair_req;
   pair_rsp_type     pair_rsp;
   logic             accept;

   function automatic logic [63:0] add_clamp(input logic [63:0] a, input logic [63:0] b);
      logic signed [63:0] s;
      s = $signed(a) + $signed(b);
      if (s > $signed(ACC_LIM)) begin
         return ACC_LIM;
      end else if (s < -$signed(ACC_LIM)) begin
         return 64'd0 - ACC_LIM;
      end
      return s;
   endfunction

   function automatic logic [31:0] sat32(input logic [63:0] a);
      if ($signed(a) > 64'sd2147483647) begin
         return 32'h7fff_ffff;
      end else if ($signed(a) < -64'sd2147483648) begin
         return 32'h8000_0000;
      end
      return a[31:0];
   endfunction

   assign accept    = start && !busy;
   assign busy      = (state_ff != T_IDLE);
   assign csr_ready = 1'b1;
   assign load_en   = accept && (count_ff < CNT_MAX);
   assign load_data = '{x: req_pos_x, y: req_pos_y, z: req_pos_z, m: req_mass};

   for (genvar k = 0; k < MAX_PARTICLES; k++) begin : g_ring
      nbga_cell u_cell (
         .clock      (clock),
         .load_en    (load_en && (count_ff == CNT_W'(k))),
         .load_data  (load_data),
         .shift_en   (rot_en),
         .shift_data (cell_q[(k + 1) % MAX_PARTICLES]),
         .q          (cell_q[k])
      );
   end

   assign pair_req = '{pi: pi_ff, pj: cell_q[0]};

   nbga_pair #(.FRAC_BITS(FRAC_BITS)) u_pair (
      .clock            (clock),
      .reset            (reset),
      .start            (pair_start),
      .req              (pair_req),
      .gravity_const    (grav_ff),
      .softening_length (soft_ff),
      .done             (pair_done),
      .rsp              (pair_rsp)
   );

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      r_in       = r_ff;
      i_in       = i_ff;
      pi_in      = pi_ff;
      ax_in      = ax_ff;
      ay_in      = ay_ff;
      az_in      = az_ff;
      rv_in      = 1'b0;
      rl_in      = rl_ff;
      rx_in      = rx_ff;
      ry_in      = ry_ff;
      rz_in      = rz_ff;
      ri_in      = ri_ff;
      rot_en     = 1'b0;
      pair_start = 1'b0;
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               if (load_en) begin
                  count_in = count_ff + 1'b1;
               end
               if (req_last_particle) begin
                  i_in     = '0;
                  r_in     = '0;
                  state_in = T_SEEK;
               end
            end
         end
         T_SEEK: begin
            rot_en = 1'b1;
            if (r_ff == i_ff) begin
               pi_in = cell_q[0];
            end
            r_in = r_ff + 1'b1;
            if (r_ff == R_LAST) begin
               r_in     = '0;
               ax_in    = '0;
               ay_in    = '0;
               az_in    = '0;
               state_in = T_SCAN;
            end
         end
         T_SCAN: begin
            if ((CNT_W'(r_ff) < count_ff) && (r_ff != i_ff)) begin
               pair_start = 1'b1;
               state_in   = T_WAIT;
            end else begin
               rot_en = 1'b1;
               r_in   = r_ff + 1'b1;
               if (r_ff == R_LAST) begin
                  r_in     = '0;
                  state_in = T_EMIT;
               end
            end
         end
         T_WAIT: begin
            if (pair_done) begin
               ax_in  = add_clamp(ax_ff, pair_rsp.cx);
               ay_in  = add_clamp(ay_ff, pair_rsp.cy);
               az_in  = add_clamp(az_ff, pair_rsp.cz);
               rot_en = 1'b1;
               r_in   = r_ff + 1'b1;
               if (r_ff == R_LAST) begin
                  r_in     = '0;
                  state_in = T_EMIT;
               end else begin
                  state_in = T_SCAN;
               end
            end
         end
         T_EMIT: begin
            rv_in = 1'b1;
            rx_in = sat32(ax_ff);
            ry_in = sat32(ay_ff);
            rz_in = sat32(az_ff);
            ri_in = i_ff;
            rl_in = (CNT_W'(i_ff) == count_ff - 1'b1);
            r_in  = '0;
            if (CNT_W'(i_ff) == count_ff - 1'b1) begin
               count_in = '0;
               state_in = T_IDLE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = T_SEEK;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         count_ff <= '0;
         r_ff     <= '0;
         i_ff     <= '0;
         rv_ff    <= 1'b0;
         grav_ff  <= 32'd65536;
         soft_ff  <= 32'd6554;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         r_ff     <= r_in;
         i_ff     <= i_in;
         rv_ff    <= rv_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_GRAVITY: grav_ff <= csr_wdata;
               CSR_SOFTEN:  soft_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pi_ff <= pi_in;
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      az_ff <= az_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      rz_ff <= rz_in;
      ri_ff <= ri_in;
      rl_ff <= rl_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_acc_x          = rx_ff;
   assign rsp_acc_y          = ry_ff;
   assign rsp_acc_z          = rz_ff;
   assign rsp_particle_index = IDX_W'(ri_ff);
   assign rsp_last_result    = rl_ff;

`ifndef SYNTH
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("particle count beyond capacity");

   a_load_only: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_last_particle) |=> !busy)
      else $error("non-final item started a run");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_result) |-> !busy)
      else $error("still busy after final result");

   a_pair_wait: assert property (@(posedge clock) disable iff (reset)
      pair_done |-> (state_ff == T_WAIT))
      else $error("pair result outside wait state");
`endif

endmodule

`default_nettype wire
